/* src/lhem_pkg.sv */
package lhem_pkg;

	localparam int MAX_SITE_ID_DEF = 1023;

	localparam int ACTION_W = 3;
	localparam int SITE_W = 10;
	localparam int TIME_W = 32;
	localparam int CNT_W = 32;
	localparam int DELAY_W = 16;
	localparam int WINDOW_W = 22;
	localparam int HEALTH_W = 2;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 22;

	localparam logic [ACTION_W-1:0] ACT_COERCE = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_BAD_MSG = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_RETRY = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_KEYSET = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_LOW_FP = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_DESTROY = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_REAUTH_DELAY = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW = 4'd1;

	localparam logic [DELAY_W-1:0] REAUTH_DELAY_RST = 16'd2000;
	localparam logic [WINDOW_W-1:0] BURST_WINDOW_RST = 22'd30000;

	localparam logic [HEALTH_W-1:0] HEALTH_OK = 2'd0;
	localparam logic [HEALTH_W-1:0] HEALTH_DEGRADED = 2'd1;
	localparam logic [HEALTH_W-1:0] HEALTH_SUSPICIOUS = 2'd2;

	// One entry of the per-site table.
	typedef struct packed {
		logic              seen;
		logic [TIME_W-1:0] last_destroy;
		logic [TIME_W-1:0] reauth;
	} site_entry_t;

	localparam int ENTRY_W = $bits(site_entry_t);

	// Counter bump request, one flag per counter.
	typedef struct packed {
		logic coerce;
		logic bad_msg;
		logic retry;
		logic keyset;
		logic low_fp;
		logic destroy;
		logic burst;
	} bump_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] coerce;
		logic [CNT_W-1:0] bad_msg;
		logic [CNT_W-1:0] retry;
		logic [CNT_W-1:0] keyset;
		logic [CNT_W-1:0] low_fp;
		logic [CNT_W-1:0] destroy;
		logic [CNT_W-1:0] burst;
	} counts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
		sat_inc = (en && (v != '1)) ? v + CNT_W'(1) : v;
	endfunction

endpackage

/* src/lhem_site_mem.sv */
module lhem_site_mem import lhem_pkg::*; #(
	parameter int DEPTH = MAX_SITE_ID_DEF + 1,
	parameter int AW = $clog2(MAX_SITE_ID_DEF + 1)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  site_entry_t       wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output site_entry_t       rdata
);

	site_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/lhem_counter_bank.sv */
module lhem_counter_bank import lhem_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  bump_req_t bump,
	output counts_t   counts,
	output logic [HEALTH_W-1:0] health
);

	counts_t cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en) begin
			cnt_q.coerce  <= sat_inc(cnt_q.coerce, bump.coerce);
			cnt_q.bad_msg <= sat_inc(cnt_q.bad_msg, bump.bad_msg);
			cnt_q.retry   <= sat_inc(cnt_q.retry, bump.retry);
			cnt_q.keyset  <= sat_inc(cnt_q.keyset, bump.keyset);
			cnt_q.low_fp  <= sat_inc(cnt_q.low_fp, bump.low_fp);
			cnt_q.destroy <= sat_inc(cnt_q.destroy, bump.destroy);
			cnt_q.burst   <= sat_inc(cnt_q.burst, bump.burst);
		end
	end

	assign counts = cnt_q;

	always_comb begin
		if ((cnt_q.coerce != '0) || (cnt_q.bad_msg != '0) || (cnt_q.keyset != '0) ||
		    (cnt_q.low_fp != '0) || (cnt_q.burst != '0)) begin
			health = HEALTH_SUSPICIOUS;
		end else if ((cnt_q.retry != '0) || (cnt_q.destroy != '0)) begin
			health = HEALTH_DEGRADED;
		end else begin
			health = HEALTH_OK;
		end
	end

	// A burst is only ever counted together with a destroy.
	a_burst_le_destroy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q.burst <= cnt_q.destroy)
		else $error("burst count exceeds destroy count");

	a_destroy_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cnt_q))
		else $error("counters changed without an update");

	a_burst_with_destroy: assert property (@(posedge clk) disable iff (!arst_n)
		en && bump.burst |-> bump.destroy)
		else $error("burst bumped without a destroy");

endmodule

/* src/link_health_event_monitor.sv */
// Link health event monitor. Each request carries an event kind, a site id and a
// millisecond timestamp and returns one result with all seven saturating counters,
// a health class and the site's reauth-not-before time. Per-site records live in
// one single-port-read, single-port-write table of MAX_SITE_ID+1 entries. After
// reset the table is cleared one entry per cycle and no request is taken until
// the clear is done; configuration writes are taken at any time. A key destroy
// at a tracked site reads its own record, then records 1 to MAX_SITE_ID, through
// the table's read port; another request at a tracked site reads only its own
// record, one at an untracked site none. One request is in flight at a time; the
// next one is taken while the previous result waits at the output.
module link_health_event_monitor import lhem_pkg::*; #(
	parameter int MAX_SITE_ID = MAX_SITE_ID_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [SITE_W-1:0]     site_id,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [HEALTH_W-1:0]   health_class,
	output logic [TIME_W-1:0]     reauth_after_ms,
	output logic [CNT_W-1:0]      coerce_count,
	output logic [CNT_W-1:0]      bad_message_count,
	output logic [CNT_W-1:0]      retry_exhausted_count,
	output logic [CNT_W-1:0]      keyset_failure_count,
	output logic [CNT_W-1:0]      low_fingerprint_count,
	output logic [CNT_W-1:0]      destroy_count,
	output logic [CNT_W-1:0]      burst_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_SITE_ID + 1;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] MAX_ADDR = AW'(MAX_SITE_ID);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [DELAY_W-1:0]  reauth_delay_q;
	logic [WINDOW_W-1:0] burst_window_q;

	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       scan_q;
	logic [ACTION_W-1:0] action_q;
	logic [AW-1:0]       site_q;
	logic                tracked_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   limit_q;
	logic                burst_q;
	logic [TIME_W-1:0]   old_reauth_q;
	logic                out_valid_q;
	logic [TIME_W-1:0]   reauth_out_q;

	logic                rd_valid_s1;
	logic                rd_own_s1;
	logic [AW-1:0]       rd_addr_s1;

	logic                in_take;
	logic                site_tracked;
	logic [TIME_W:0]     limit_sum;
	logic                out_free;
	logic                finish;
	logic                is_destroy;
	logic [TIME_W-1:0]   new_reauth;
	logic [TIME_W:0]     window_end;
	logic                in_window;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	site_entry_t         mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	site_entry_t         mem_rdata;

	bump_req_t           bump;
	counts_t             counts;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign site_tracked = (site_id != '0) && (32'(site_id) <= MAX_SITE_ID);
	assign limit_sum = {1'b0, now_ms} + {{(TIME_W + 1 - DELAY_W){1'b0}}, reauth_delay_q};

	assign out_free = !out_valid_q || !out_stall;
	assign finish = (state_q == ST_DONE) && out_free;
	assign is_destroy = (action_q == ACT_DESTROY);
	assign new_reauth = (limit_q > old_reauth_q) ? limit_q : old_reauth_q;

	// Another site counts toward a burst if its last destroy plus the window
	// reaches the current time; the sum is kept one bit wider so it cannot wrap.
	assign window_end = {1'b0, mem_rdata.last_destroy} +
		{{(TIME_W + 1 - WINDOW_W){1'b0}}, burst_window_q};
	assign in_window = mem_rdata.seen && (window_end >= {1'b0, now_q});

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = site_q;
		mem_wdata = '{seen: 1'b1, last_destroy: now_q, reauth: new_reauth};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (finish && is_destroy && tracked_q) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re = (state_q == ST_LOOKUP) || (state_q == ST_SCAN);
	assign mem_raddr = (state_q == ST_LOOKUP) ? site_q : scan_q;

	always_comb begin
		bump = '0;
		case (action_q)
			ACT_COERCE:  bump.coerce = 1'b1;
			ACT_BAD_MSG: bump.bad_msg = 1'b1;
			ACT_RETRY:   bump.retry = 1'b1;
			ACT_KEYSET:  bump.keyset = 1'b1;
			ACT_LOW_FP:  bump.low_fp = 1'b1;
			ACT_DESTROY: begin
				bump.destroy = 1'b1;
				bump.burst = tracked_q && burst_q;
			end
			default: bump = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reauth_delay_q <= REAUTH_DELAY_RST;
			burst_window_q <= BURST_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REAUTH_DELAY: reauth_delay_q <= cfg_data[DELAY_W-1:0];
				REG_BURST_WINDOW: burst_window_q <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Read pipeline tag: what the data coming out of the table belongs to.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_own_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
			rd_own_s1 <= (state_q == ST_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			scan_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == MAX_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						state_q <= site_tracked ? ST_LOOKUP : ST_DONE;
					end
				end
				ST_LOOKUP: begin
					scan_q <= AW'(1);
					state_q <= is_destroy ? ST_SCAN : ST_DRAIN;
				end
				ST_SCAN: begin
					scan_q <= scan_q + AW'(1);
					if (scan_q == MAX_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_q <= action;
			site_q <= AW'(site_id);
			tracked_q <= site_tracked;
			now_q <= now_ms;
			limit_q <= limit_sum[TIME_W] ? '1 : limit_sum[TIME_W-1:0];
			burst_q <= 1'b0;
			old_reauth_q <= '0;
		end else if (rd_valid_s1) begin
			if (rd_own_s1) begin
				old_reauth_q <= mem_rdata.reauth;
			end else if ((rd_addr_s1 != site_q) && in_window) begin
				burst_q <= 1'b1;
			end
		end
		if (finish) begin
			if (!tracked_q) begin
				reauth_out_q <= '0;
			end else if (is_destroy) begin
				reauth_out_q <= new_reauth;
			end else begin
				reauth_out_q <= old_reauth_q;
			end
		end
	end

	lhem_site_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_site_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	lhem_counter_bank u_counters (
		.clk(clk),
		.arst_n(arst_n),
		.en(finish),
		.bump(bump),
		.counts(counts),
		.health(health_class)
	);

	assign out_valid = out_valid_q;
	assign reauth_after_ms = reauth_out_q;
	assign coerce_count = counts.coerce;
	assign bad_message_count = counts.bad_msg;
	assign retry_exhausted_count = counts.retry;
	assign keyset_failure_count = counts.keyset;
	assign low_fingerprint_count = counts.low_fp;
	assign destroy_count = counts.destroy;
	assign burst_count = counts.burst;

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR) || (state_q == ST_DONE))
		else $error("table written outside clear or finish");

	a_read_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
		else $error("read data returned in an unexpected state");

	a_finish_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished request did not reach the output");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !finish)
		else $error("result overwritten while stalled");

endmodule

/* bench/tb_link_health_event_monitor.sv */
module tb_link_health_event_monitor;
	timeunit 1ns;
	timeprecision 1ps;

	import lhem_pkg::*;

	// The package names only the counted actions; query and the spare code are local.
	localparam logic [ACTION_W-1:0] ACT_QUERY = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

	localparam int NUM_COUNTERS = 7;
	localparam int NUM_PHASES = 8;
	localparam int REQUESTS_PER_PHASE = 70;
	localparam int HOLD_OFF_CYCLES = 4000;
	localparam int DRAIN_CYCLES = MAX_SITE_ID_DEF + 16;

	typedef enum int {
		EV_COERCE, EV_BAD_MSG, EV_RETRY, EV_KEYSET, EV_LOW_FP, EV_DESTROY, EV_BURST
	} counter_e;

	typedef struct packed {
		logic [HEALTH_W-1:0]                  health;
		logic [TIME_W-1:0]                    reauth;
		logic [NUM_COUNTERS-1:0][CNT_W-1:0]   counts;
	} link_status_t;

	class link_health_scoreboard;
		logic [DELAY_W-1:0]                 delay_ms;
		logic [WINDOW_W-1:0]                window_ms;
		logic [NUM_COUNTERS-1:0][CNT_W-1:0] counters;
		bit                                 seen [0:MAX_SITE_ID_DEF];
		logic [TIME_W-1:0]                  last_destroy [0:MAX_SITE_ID_DEF];
		logic [TIME_W-1:0]                  reauth_at [0:MAX_SITE_ID_DEF];
		link_status_t                       status_q [$];
		string                              counter_names [NUM_COUNTERS];
		int                                 errors;

		function new();
			delay_ms = REAUTH_DELAY_RST;
			window_ms = BURST_WINDOW_RST;
			counters = '0;
			foreach (seen[i]) begin
				seen[i] = 1'b0;
				last_destroy[i] = '0;
				reauth_at[i] = '0;
			end
			counter_names = '{"coerce_count", "bad_message_count", "retry_exhausted_count",
				"keyset_failure_count", "low_fingerprint_count", "destroy_count",
				"burst_count"};
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_REAUTH_DELAY) begin
				delay_ms = data[DELAY_W-1:0];
			end else if (idx == REG_BURST_WINDOW) begin
				window_ms = data[WINDOW_W-1:0];
			end
		endfunction

		function void bump(int k);
			if (counters[k] != '1)
				counters[k] = counters[k] + 1'b1;
		endfunction

		function bit tracked(logic [SITE_W-1:0] site);
			return site >= 1 && site <= MAX_SITE_ID_DEF;
		endfunction

		function void note_request(logic [ACTION_W-1:0] act, logic [SITE_W-1:0] site,
				logic [TIME_W-1:0] now);
			logic [TIME_W:0] reach;
			logic [TIME_W:0] limit;
			link_status_t st;
			bit hit;
			hit = 1'b0;
			case (act)
				// The first five action codes line up with the counter order.
				ACT_COERCE, ACT_BAD_MSG, ACT_RETRY, ACT_KEYSET, ACT_LOW_FP: begin
					bump(int'(act));
				end
				ACT_DESTROY: begin
					bump(EV_DESTROY);
					if (tracked(site)) begin
						for (int s = 1; s <= MAX_SITE_ID_DEF && !hit; s++) begin
							if (s != site && seen[s]) begin
								reach = {1'b0, last_destroy[s]} + window_ms;
								if (reach >= {1'b0, now})
									hit = 1'b1;
							end
						end
						if (hit)
							bump(EV_BURST);
						seen[site] = 1'b1;
						last_destroy[site] = now;
						limit = {1'b0, now} + delay_ms;
						if (limit[TIME_W])
							limit = '1;
						if (limit[TIME_W-1:0] > reauth_at[site])
							reauth_at[site] = limit[TIME_W-1:0];
					end
				end
				default: ;
			endcase
			st.counts = counters;
			if (counters[EV_COERCE] != 0 || counters[EV_BAD_MSG] != 0 ||
					counters[EV_KEYSET] != 0 || counters[EV_LOW_FP] != 0 ||
					counters[EV_BURST] != 0)
				st.health = HEALTH_SUSPICIOUS;
			else if (counters[EV_RETRY] != 0 || counters[EV_DESTROY] != 0)
				st.health = HEALTH_DEGRADED;
			else
				st.health = HEALTH_OK;
			st.reauth = tracked(site) ? reauth_at[site] : '0;
			status_q.push_back(st);
		endfunction

		function void check_result(link_status_t got);
			link_status_t want;
			if (status_q.size() == 0) begin
				$display("%0t: result with no request outstanding, health %0d reauth %0h",
					$time, got.health, got.reauth);
				errors++;
				return;
			end
			want = status_q.pop_front();
			if (got.health !== want.health) begin
				$display("%0t: health_class expected %0d got %0d", $time, want.health,
					got.health);
				errors++;
			end
			if (got.reauth !== want.reauth) begin
				$display("%0t: reauth_after_ms expected %0h got %0h", $time, want.reauth,
					got.reauth);
				errors++;
			end
			for (int j = 0; j < NUM_COUNTERS; j++) begin
				if (got.counts[j] !== want.counts[j]) begin
					$display("%0t: %s expected %0d got %0d", $time, counter_names[j],
						want.counts[j], got.counts[j]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [ACTION_W-1:0]   action;
	logic [SITE_W-1:0]     site_id;
	logic [TIME_W-1:0]     now_ms;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [HEALTH_W-1:0]   health_class;
	logic [TIME_W-1:0]     reauth_after_ms;
	logic [CNT_W-1:0]      coerce_count;
	logic [CNT_W-1:0]      bad_message_count;
	logic [CNT_W-1:0]      retry_exhausted_count;
	logic [CNT_W-1:0]      keyset_failure_count;
	logic [CNT_W-1:0]      low_fingerprint_count;
	logic [CNT_W-1:0]      destroy_count;
	logic [CNT_W-1:0]      burst_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	link_health_scoreboard sb;

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	logic [TIME_W-1:0] clock_ms;
	logic [SITE_W-1:0] site_pool [4];

	link_health_event_monitor dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.action                (action),
		.site_id               (site_id),
		.now_ms                (now_ms),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.health_class          (health_class),
		.reauth_after_ms       (reauth_after_ms),
		.coerce_count          (coerce_count),
		.bad_message_count     (bad_message_count),
		.retry_exhausted_count (retry_exhausted_count),
		.keyset_failure_count  (keyset_failure_count),
		.low_fingerprint_count (low_fingerprint_count),
		.destroy_count         (destroy_count),
		.burst_count           (burst_count),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A pending hold-off takes priority over the random stall of the current phase.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		link_status_t st;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			st.health = health_class;
			st.reauth = reauth_after_ms;
			st.counts[EV_COERCE] = coerce_count;
			st.counts[EV_BAD_MSG] = bad_message_count;
			st.counts[EV_RETRY] = retry_exhausted_count;
			st.counts[EV_KEYSET] = keyset_failure_count;
			st.counts[EV_LOW_FP] = low_fingerprint_count;
			st.counts[EV_DESTROY] = destroy_count;
			st.counts[EV_BURST] = burst_count;
			sb.check_result(st);
		end
	end

	// Entered and left at a falling edge; valid stays high after acceptance until the
	// next call lowers it for a gap or replaces the payload, or the caller lowers it.
	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [SITE_W-1:0] site,
			input logic [TIME_W-1:0] now);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		site_id <= site;
		now_ms <= now;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_request(act, site, now);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		sb.write_register(idx, data);
		@(negedge clk);
	endtask

	// Upper data bits are random on the delay write; only the low bits may take effect.
	task automatic apply_settings(input logic [DELAY_W-1:0] delay,
			input logic [WINDOW_W-1:0] window, input bit poke_unused);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[DELAY_W-1:0] = delay;
		cfg_write(REG_REAUTH_DELAY, d);
		cfg_write(REG_BURST_WINDOW, CFG_DATA_W'(window));
		if (poke_unused)
			cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained(input int settle);
		while (sb.status_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly a small pool of sites and a slowly advancing clock, so that destroys fall
	// inside and outside the window; now and then a jump, which may go backwards.
	task automatic random_request(output logic [ACTION_W-1:0] act,
			output logic [SITE_W-1:0] site, output logic [TIME_W-1:0] now);
		int r;
		int unsigned span;
		r = $urandom_range(0, 99);
		if (r < 30)
			act = ACT_DESTROY;
		else if (r < 40)
			act = $urandom_range(0, 1) ? ACT_QUERY : ACT_SPARE;
		else
			act = ACTION_W'($urandom_range(int'(ACT_COERCE), int'(ACT_LOW_FP)));
		r = $urandom_range(0, 99);
		if (r < 60)
			site = site_pool[$urandom_range(0, 3)];
		else if (r < 72)
			site = '0;
		else
			site = SITE_W'($urandom);
		span = (sb.window_ms == 0) ? 3 : 2 * int'(sb.window_ms);
		r = $urandom_range(0, 99);
		if (r < 4)
			clock_ms = $urandom;
		else if (r < 6)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100000);
		else
			clock_ms = clock_ms + $urandom_range(0, span);
		now = clock_ms;
	endtask

	initial begin
		logic [ACTION_W-1:0] a;
		logic [SITE_W-1:0] s;
		logic [TIME_W-1:0] t;
		logic [DELAY_W-1:0] delay;
		logic [WINDOW_W-1:0] window;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_QUERY;
		site_id = '0;
		now_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_REAUTH_DELAY;
		cfg_data = '0;
		clock_ms = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests under the reset settings.
		send_request(ACT_QUERY, 10'd0, 32'd0);
		send_request(ACT_DESTROY, 10'd5, 32'd0);
		send_request(ACT_RETRY, 10'd0, 32'd10);
		// The window reaches back past time zero, so the destroy at zero counts.
		send_request(ACT_DESTROY, 10'h3FF, 32'd100);
		send_request(ACT_DESTROY, 10'd0, 32'd200);
		// Time runs backwards; the stored reauth time must not shrink.
		send_request(ACT_DESTROY, 10'h3FF, 32'd50);
		send_request(ACT_SPARE, 10'h3FF, 32'd60);
		send_request(ACT_DESTROY, 10'd700, 32'hFFFF_FFFF);
		// Last time plus window passes 32 bits here.
		send_request(ACT_DESTROY, 10'd1, 32'hFFFF_FFF0);
		send_request(ACT_QUERY, 10'd700, 32'hFFFF_FFFF);
		send_request(ACT_COERCE, 10'h2AA, 32'hAAAA_AAAA);
		send_request(ACT_BAD_MSG, 10'h155, 32'h5555_5555);
		send_request(ACT_KEYSET, 10'd1, 32'h0000_FFFF);
		send_request(ACT_LOW_FP, 10'h3FF, 32'hFFFF_0000);
		send_request(ACT_RETRY, 10'h200, 32'h8000_0000);
		send_request(ACT_DESTROY, 10'd5, 32'h0000_8000);
		send_request(ACT_QUERY, 10'd5, 32'h0000_8000);
		in_valid <= 1'b0;
		wait_drained(8);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin delay = '0; window = '0; end
				1: begin delay = '1; window = '1; end
				3: begin delay = 16'd1; window = 22'd1; end
				4: begin delay = REAUTH_DELAY_RST; window = BURST_WINDOW_RST; end
				2, 6: begin
					delay = DELAY_W'($urandom);
					window = WINDOW_W'($urandom_range(0, 100000));
				end
				default: begin
					delay = DELAY_W'($urandom);
					window = WINDOW_W'($urandom);
				end
			endcase
			apply_settings(delay, window, phase == 3);
			case (phase % 4)
				0: begin sender_idle_pct = 0; stall_pct = 0; end
				1: begin sender_idle_pct = 60; stall_pct = 0; end
				2: begin sender_idle_pct = 0; stall_pct = 60; end
				default: begin sender_idle_pct = 20; stall_pct = 20; end
			endcase
			site_pool[0] = 10'd1;
			site_pool[1] = SITE_W'(MAX_SITE_ID_DEF);
			site_pool[2] = SITE_W'($urandom_range(1, MAX_SITE_ID_DEF));
			site_pool[3] = SITE_W'($urandom_range(1, MAX_SITE_ID_DEF));
			// The receiver holds off long enough that the block backs up into its input.
			if (phase == 2)
				hold_request = HOLD_OFF_CYCLES;
			for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
				random_request(a, s, t);
				send_request(a, s, t);
			end
			in_valid <= 1'b0;
			wait_drained(phase == NUM_PHASES - 1 ? DRAIN_CYCLES : 8);
		end

		if (sb.errors == 0 && sb.status_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (sb.status_q.size() != 0)
				$display("%0t: %0d results never arrived", $time, sb.status_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("%0t: timed out with %0d results outstanding", $time, sb.status_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
src/lhem_pkg.sv
src/lhem_site_mem.sv
src/lhem_counter_bank.sv
src/link_health_event_monitor.sv
bench/tb_link_health_event_monitor.sv
